// ----- rtl/segment_intersection_assert.svh -----
// Assertion macros for the segment intersection block
`ifndef SEGMENT_INTERSECTION_ASSERT_SVH
`define SEGMENT_INTERSECTION_ASSERT_SVH

// clocked check, switched off while reset is high
`define SI_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked implication, switched off while reset is high
`define SI_ASSERT_IMP(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

`endif

// ----- rtl/si_pkg.sv -----
// Shared types and status codes for the segment intersection block
`timescale 1ns / 1ps
package si_pkg;

   typedef enum logic [1:0] {
      ST_HIT        = 2'd0,
      ST_ZERO_LEN   = 2'd1,
      ST_PARALLEL   = 2'd2,
      ST_OUTSIDE    = 2'd3
   } status_type;

   // control travelling alongside each item in the pipeline
   typedef struct packed {
      logic       valid;
      logic       zero_len;
      status_type status;
   } ctrl_type;

endpackage

// ----- rtl/si_front.sv -----
// Front end: deltas, cross products, numerators and classification
`timescale 1ns / 1ps
module si_front #(
   parameter int C = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [C-1:0]           ax0,
   input  logic [C-1:0]           ay0,
   input  logic [C-1:0]           ax1,
   input  logic [C-1:0]           ay1,
   input  logic [C-1:0]           bx0,
   input  logic [C-1:0]           by0,
   input  logic [C-1:0]           bx1,
   input  logic [C-1:0]           by1,
   output si_pkg::ctrl_type       ctrl_out,
   output logic [2*C+1:0]         na_mag,
   output logic [2*C+1:0]         den_mag,
   output logic [C-1:0]           dx_mag,
   output logic [C-1:0]           dy_mag,
   output logic                   neg_x,
   output logic                   neg_y,
   output logic [C-1:0]           base_x,
   output logic [C-1:0]           base_y
);
   localparam int DEL_W = C + 1;
   localparam int PRD_W = 2 * DEL_W;
   localparam int NUM_W = PRD_W + 1;
   localparam int MAG_W = 2 * C + 2;

   // stage 1: differences
   si_pkg::ctrl_type           s1_ctrl_ff, s1_ctrl_in;
   logic signed [DEL_W-1:0]    dxa_ff, dya_ff, dxb_ff, dyb_ff, ex_ff, ey_ff;
   logic [C-1:0]               s1_bx_ff, s1_by_ff;

   always_comb begin
      s1_ctrl_in.valid    = in_valid;
      s1_ctrl_in.zero_len = ((ax0 == ax1) && (ay0 == ay1)) || ((bx0 == bx1) && (by0 == by1));
      s1_ctrl_in.status   = si_pkg::ST_HIT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctrl_ff <= '0;
      end else begin
         s1_ctrl_ff <= s1_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      dxa_ff   <= {ax1[C-1], ax1} - {ax0[C-1], ax0};
      dya_ff   <= {ay1[C-1], ay1} - {ay0[C-1], ay0};
      dxb_ff   <= {bx1[C-1], bx1} - {bx0[C-1], bx0};
      dyb_ff   <= {by1[C-1], by1} - {by0[C-1], by0};
      ex_ff    <= {ax0[C-1], ax0} - {bx0[C-1], bx0};
      ey_ff    <= {ay0[C-1], ay0} - {by0[C-1], by0};
      s1_bx_ff <= ax0;
      s1_by_ff <= ay0;
   end

   // stage 2: six cross products
   si_pkg::ctrl_type           s2_ctrl_ff;
   logic signed [PRD_W-1:0]    p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [DEL_W-1:0]    s2_dxa_ff, s2_dya_ff;
   logic [C-1:0]               s2_bx_ff, s2_by_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctrl_ff <= '0;
      end else begin
         s2_ctrl_ff <= s1_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      p0_ff     <= dyb_ff * dxa_ff;
      p1_ff     <= dxb_ff * dya_ff;
      p2_ff     <= dxb_ff * ey_ff;
      p3_ff     <= dyb_ff * ex_ff;
      p4_ff     <= dxa_ff * ey_ff;
      p5_ff     <= dya_ff * ex_ff;
      s2_dxa_ff <= dxa_ff;
      s2_dya_ff <= dya_ff;
      s2_bx_ff  <= s1_bx_ff;
      s2_by_ff  <= s1_by_ff;
   end

   // stage 3: denominator and numerators
   si_pkg::ctrl_type           s3_ctrl_ff;
   logic signed [NUM_W-1:0]    den_ff, na_ff, nb_ff;
   logic signed [DEL_W-1:0]    s3_dxa_ff, s3_dya_ff;
   logic [C-1:0]               s3_bx_ff, s3_by_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctrl_ff <= '0;
      end else begin
         s3_ctrl_ff <= s2_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      den_ff    <= {p0_ff[PRD_W-1], p0_ff} - {p1_ff[PRD_W-1], p1_ff};
      na_ff     <= {p2_ff[PRD_W-1], p2_ff} - {p3_ff[PRD_W-1], p3_ff};
      nb_ff     <= {p4_ff[PRD_W-1], p4_ff} - {p5_ff[PRD_W-1], p5_ff};
      s3_dxa_ff <= s2_dxa_ff;
      s3_dya_ff <= s2_dya_ff;
      s3_bx_ff  <= s2_bx_ff;
      s3_by_ff  <= s2_by_ff;
   end

   // stage 4: range test on both parameters, magnitudes and signs
   logic [NUM_W-1:0] den_neg, na_neg, nb_neg;
   logic [DEL_W-1:0] dxa_neg, dya_neg;
   logic [MAG_W-1:0] den_abs, na_abs, nb_abs;
   logic             ua_ok, ub_ok;
   si_pkg::ctrl_type s4_ctrl_in, s4_ctrl_ff;

   always_comb begin
      den_neg = -den_ff;
      na_neg  = -na_ff;
      nb_neg  = -nb_ff;
      dxa_neg = -s3_dxa_ff;
      dya_neg = -s3_dya_ff;
      den_abs = den_ff[NUM_W-1] ? den_neg[MAG_W-1:0] : den_ff[MAG_W-1:0];
      na_abs  = na_ff[NUM_W-1]  ? na_neg[MAG_W-1:0]  : na_ff[MAG_W-1:0];
      nb_abs  = nb_ff[NUM_W-1]  ? nb_neg[MAG_W-1:0]  : nb_ff[MAG_W-1:0];
      ua_ok   = (na_ff == '0) ||
                ((na_ff[NUM_W-1] == den_ff[NUM_W-1]) && (na_abs <= den_abs));
      ub_ok   = (nb_ff == '0) ||
                ((nb_ff[NUM_W-1] == den_ff[NUM_W-1]) && (nb_abs <= den_abs));
   end

   always_comb begin
      s4_ctrl_in = s3_ctrl_ff;
      priority if (s3_ctrl_ff.zero_len) begin
         s4_ctrl_in.status = si_pkg::ST_ZERO_LEN;
      end else if (den_ff == '0) begin
         s4_ctrl_in.status = si_pkg::ST_PARALLEL;
      end else if (!ua_ok || !ub_ok) begin
         s4_ctrl_in.status = si_pkg::ST_OUTSIDE;
      end else begin
         s4_ctrl_in.status = si_pkg::ST_HIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ctrl_ff <= '0;
      end else begin
         s4_ctrl_ff <= s4_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      na_mag  <= na_abs;
      den_mag <= den_abs;
      dx_mag  <= s3_dxa_ff[DEL_W-1] ? dxa_neg[C-1:0] : s3_dxa_ff[C-1:0];
      dy_mag  <= s3_dya_ff[DEL_W-1] ? dya_neg[C-1:0] : s3_dya_ff[C-1:0];
      neg_x   <= na_ff[NUM_W-1] ^ den_ff[NUM_W-1] ^ s3_dxa_ff[DEL_W-1];
      neg_y   <= na_ff[NUM_W-1] ^ den_ff[NUM_W-1] ^ s3_dya_ff[DEL_W-1];
      base_x  <= s3_bx_ff;
      base_y  <= s3_by_ff;
   end

   assign ctrl_out = s4_ctrl_ff;

endmodule

// ----- rtl/si_div_stage.sv -----
// One step of the merged multiply-divide: quotient digit 0..2 per delta bit
`timescale 1ns / 1ps
module si_div_stage #(
   parameter int C = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  si_pkg::ctrl_type  ctrl_in,
   input  logic [2*C+1:0]    na_in,
   input  logic [2*C+1:0]    den_in,
   input  logic [2*C+1:0]    rem_in   [2],
   input  logic [C-1:0]      quo_in   [2],
   input  logic [C-1:0]      dmag_in  [2],
   input  logic              neg_in   [2],
   input  logic [C-1:0]      base_in  [2],
   output si_pkg::ctrl_type  ctrl_out,
   output logic [2*C+1:0]    na_out,
   output logic [2*C+1:0]    den_out,
   output logic [2*C+1:0]    rem_out  [2],
   output logic [C-1:0]      quo_out  [2],
   output logic [C-1:0]      dmag_out [2],
   output logic              neg_out  [2],
   output logic [C-1:0]      base_out [2]
);
   localparam int MAG_W = 2 * C + 2;
   localparam int T_W   = MAG_W + 2;

   si_pkg::ctrl_type   ctrl_ff;
   logic [MAG_W-1:0]   na_ff, den_ff;
   logic [MAG_W-1:0]   rem_ff [2];
   logic [MAG_W-1:0]   rem_in_c [2];
   logic [C-1:0]       quo_ff [2], dmag_ff [2], base_ff [2];
   logic [C-1:0]       quo_in_c [2];
   logic               neg_ff [2];
   logic [T_W-1:0]     d1, d2;
   logic [T_W-1:0]     t [2];

   // rem = 2*rem + bit*na, then take out up to twice the denominator
   always_comb begin
      d1 = {2'b00, den_in};
      d2 = {1'b0, den_in, 1'b0};
      for (int k = 0; k < 2; k++) begin
         t[k] = {1'b0, rem_in[k], 1'b0} + (dmag_in[k][C-1] ? {2'b00, na_in} : '0);
         if (t[k] >= d2) begin
            rem_in_c[k] = MAG_W'(t[k] - d2);
            quo_in_c[k] = {quo_in[k][C-2:0], 1'b0} + C'(2);
         end else if (t[k] >= d1) begin
            rem_in_c[k] = MAG_W'(t[k] - d1);
            quo_in_c[k] = {quo_in[k][C-2:0], 1'b1};
         end else begin
            rem_in_c[k] = t[k][MAG_W-1:0];
            quo_in_c[k] = {quo_in[k][C-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      na_ff  <= na_in;
      den_ff <= den_in;
      for (int k = 0; k < 2; k++) begin
         rem_ff[k]  <= rem_in_c[k];
         quo_ff[k]  <= quo_in_c[k];
         dmag_ff[k] <= {dmag_in[k][C-2:0], 1'b0};
         neg_ff[k]  <= neg_in[k];
         base_ff[k] <= base_in[k];
      end
   end

   assign ctrl_out = ctrl_ff;
   assign na_out   = na_ff;
   assign den_out  = den_ff;
   assign rem_out  = rem_ff;
   assign quo_out  = quo_ff;
   assign dmag_out = dmag_ff;
   assign neg_out  = neg_ff;
   assign base_out = base_ff;

endmodule

// ----- rtl/segment_intersection.sv -----
// Top level of the segment intersection pipeline
`timescale 1ns / 1ps
`include "segment_intersection_assert.svh"
// Segment intersection, fully pipelined.
// Request channel: the eight endpoint coordinates req_ax0..req_by1, signed
// fixed point, COORD_BITS wide. A transfer happens at each rising edge with
// start high and busy low. busy never rises, so one segment pair can be
// taken every cycle.
// Response channel: rsp_valid is high for one cycle with rsp_status,
// rsp_hit_x and rsp_hit_y. Status 0 is a hit, 1 a zero-length segment,
// 2 parallel, 3 crossing outside a segment; the point is zero unless a hit.
// The pipeline has four front stages (differences, products, numerators,
// range test), one stage per bit of the segment delta in the
// shift-add-subtract unit that forms numerator * delta / denominator,
// and one output add stage. Throughput is one item per cycle.
// Reset clears every valid bit; items in flight are dropped and no response
// follows reset until a new request is taken. The receiver has no way to
// stall, so responses appear in request order.
module segment_intersection #(
   parameter int COORD_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [COORD_BITS-1:0] req_ax0,
   input  logic [COORD_BITS-1:0] req_ay0,
   input  logic [COORD_BITS-1:0] req_ax1,
   input  logic [COORD_BITS-1:0] req_ay1,
   input  logic [COORD_BITS-1:0] req_bx0,
   input  logic [COORD_BITS-1:0] req_by0,
   input  logic [COORD_BITS-1:0] req_bx1,
   input  logic [COORD_BITS-1:0] req_by1,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [COORD_BITS-1:0] rsp_hit_x,
   output logic [COORD_BITS-1:0] rsp_hit_y
);
   localparam int C       = COORD_BITS;
   localparam int MAG_W   = 2 * C + 2;
   localparam int LATENCY = C + 5;

   // front end
   si_pkg::ctrl_type ctrl_c [C+1];
   logic [MAG_W-1:0] na_c   [C+1];
   logic [MAG_W-1:0] den_c  [C+1];
   logic [MAG_W-1:0] rem_c  [C+1][2];
   logic [C-1:0]     quo_c  [C+1][2];
   logic [C-1:0]     dmag_c [C+1][2];
   logic             neg_c  [C+1][2];
   logic [C-1:0]     base_c [C+1][2];

   assign busy = 1'b0;

   si_front #(.C(C)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .ax0      (req_ax0),
      .ay0      (req_ay0),
      .ax1      (req_ax1),
      .ay1      (req_ay1),
      .bx0      (req_bx0),
      .by0      (req_by0),
      .bx1      (req_bx1),
      .by1      (req_by1),
      .ctrl_out (ctrl_c[0]),
      .na_mag   (na_c[0]),
      .den_mag  (den_c[0]),
      .dx_mag   (dmag_c[0][0]),
      .dy_mag   (dmag_c[0][1]),
      .neg_x    (neg_c[0][0]),
      .neg_y    (neg_c[0][1]),
      .base_x   (base_c[0][0]),
      .base_y   (base_c[0][1])
   );

   // running remainder and quotient start at zero
   assign rem_c[0][0] = '0;
   assign rem_c[0][1] = '0;
   assign quo_c[0][0] = '0;
   assign quo_c[0][1] = '0;

   // one stage per delta bit, most significant first
   for (genvar s = 0; s < C; s++) begin : g_div
      si_div_stage #(.C(C)) u_stage (
         .clock    (clock),
         .reset    (reset),
         .ctrl_in  (ctrl_c[s]),
         .na_in    (na_c[s]),
         .den_in   (den_c[s]),
         .rem_in   (rem_c[s]),
         .quo_in   (quo_c[s]),
         .dmag_in  (dmag_c[s]),
         .neg_in   (neg_c[s]),
         .base_in  (base_c[s]),
         .ctrl_out (ctrl_c[s+1]),
         .na_out   (na_c[s+1]),
         .den_out  (den_c[s+1]),
         .rem_out  (rem_c[s+1]),
         .quo_out  (quo_c[s+1]),
         .dmag_out (dmag_c[s+1]),
         .neg_out  (neg_c[s+1]),
         .base_out (base_c[s+1])
      );
   end

   // output stage: base plus or minus the truncated quotient
   logic             valid_ff;
   logic [1:0]       status_ff;
   logic [C-1:0]     hit_x_ff, hit_y_ff, hit_x_in, hit_y_in;
   logic             is_hit;

   always_comb begin
      is_hit   = (ctrl_c[C].status == si_pkg::ST_HIT);
      hit_x_in = neg_c[C][0] ? base_c[C][0] - quo_c[C][0] : base_c[C][0] + quo_c[C][0];
      hit_y_in = neg_c[C][1] ? base_c[C][1] - quo_c[C][1] : base_c[C][1] + quo_c[C][1];
      if (!is_hit) begin
         hit_x_in = '0;
         hit_y_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctrl_c[C].valid;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= ctrl_c[C].status;
      hit_x_ff  <= hit_x_in;
      hit_y_ff  <= hit_y_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_status = status_ff;
   assign rsp_hit_x  = hit_x_ff;
   assign rsp_hit_y  = hit_y_ff;

   // checks
   `SI_ASSERT(a_never_busy, !busy, "busy raised on a free-running pipeline")
   `SI_ASSERT_IMP(a_resp_has_req, rsp_valid, $past(start, LATENCY), "response without a request")
   `SI_ASSERT_IMP(a_miss_zero, rsp_valid && (rsp_status != si_pkg::ST_HIT),
      (rsp_hit_x == '0) && (rsp_hit_y == '0), "miss response carries a point")

endmodule
